>>> rtl/imuaf_pkg.sv
// shared types, constants and the arctangent table for the attitude filter
package imuaf_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_FRAC_DEF   = 8;
  localparam int ZFRAC            = 16;
  localparam int TABLE_LEN        = 24;
  localparam int TBL_IDX_W        = 5;
  localparam int XY_W             = 28;
  localparam int Z_W              = 26;
  localparam int DEN_W            = 26;
  localparam int BEAT_W           = 21;
  localparam int OUT_ANG_W        = 19;

  localparam logic [DEN_W-1:0] GYRO_DIV  = 26'd65535000;
  localparam logic [DEN_W-1:0] GYRO_HALF = 26'd32767500;
  localparam logic [DEN_W-1:0] FUSE_DIV  = 26'd50;
  localparam logic [DEN_W-1:0] FUSE_HALF = 26'd25;
  localparam logic [7:0]       SPACE_KEY = 8'd32;
  localparam logic [BEAT_W-1:0] BEAT_MAX = 21'h1fffff;
  localparam logic signed [OUT_ANG_W-1:0] SAT_MAX = 19'sh3ffff;
  localparam logic signed [OUT_ANG_W-1:0] SAT_MIN = -19'sh40000;
  localparam logic signed [Z_W-1:0] Z_QUARTER = 26'sd5898240;

  typedef enum logic [2:0] {
    CFG_GYRO_X_OFF  = 3'd0,
    CFG_GYRO_Y_OFF  = 3'd1,
    CFG_GYRO_Z_OFF  = 3'd2,
    CFG_ROLL_OFF    = 3'd3,
    CFG_PITCH_OFF   = 3'd4,
    CFG_ANGLE_LIM   = 3'd5,
    CFG_RATE_LIM    = 3'd6,
    CFG_BEAT_TMO    = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CAUSE_NONE  = 2'd0,
    CAUSE_KEY   = 2'd1,
    CAUSE_ANGLE = 2'd2,
    CAUSE_RATE  = 2'd3
  } cause_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PITCH,
    S_ROLL,
    S_DELTA_R,
    S_DELTA_P,
    S_FUSE_R,
    S_FUSE_P,
    S_CHECK
  } state_t;

  // atan(2^-i) in degrees, 16 fractional bits
  function automatic logic signed [Z_W-1:0] atan_deg(input logic [TBL_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    unique case (idx)
      5'd0:  v = 26'sd2949120;
      5'd1:  v = 26'sd1740967;
      5'd2:  v = 26'sd919879;
      5'd3:  v = 26'sd466945;
      5'd4:  v = 26'sd234379;
      5'd5:  v = 26'sd117304;
      5'd6:  v = 26'sd58666;
      5'd7:  v = 26'sd29335;
      5'd8:  v = 26'sd14668;
      5'd9:  v = 26'sd7334;
      5'd10: v = 26'sd3667;
      5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;
      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;
      5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;
      5'd19: v = 26'sd7;
      5'd20: v = 26'sd4;
      5'd21: v = 26'sd2;
      5'd22: v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/imuaf_cordic.sv
// iterative vectoring cordic giving atan2 in degrees
module imuaf_cordic import imuaf_pkg::*; #(
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [15:0]    y_in,
  input  logic signed [16:0]    x_in,
  output logic                  done,
  output logic signed [Z_W-1:0] angle
);

  localparam int CNT_W = $clog2(CORDIC_STEPS + 1);
  localparam int SH    = ZFRAC - ANGLE_FRAC_BITS;
  localparam logic signed [Z_W-1:0] RND = Z_W'(1) <<< (SH - 1);

  logic signed [XY_W-1:0] x_r, y_r, x_nxt, y_nxt, xs, ys, x_ld, y_ld, dx, dy;
  logic signed [Z_W-1:0]  z_r, z_nxt, z_ld, z_rnd, angle_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   run_r, done_r;

  always_comb begin
    xs = XY_W'(x_in) <<< 8;
    ys = XY_W'(y_in) <<< 8;
    x_ld = xs;
    y_ld = ys;
    z_ld = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        x_ld = ys;
        y_ld = -xs;
        z_ld = Z_QUARTER;
      end else begin
        x_ld = -ys;
        y_ld = xs;
        z_ld = -Z_QUARTER;
      end
    end
    dx = y_r >>> cnt_r;
    dy = x_r >>> cnt_r;
    if (y_r >= 0) begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + atan_deg(TBL_IDX_W'(cnt_r));
    end else begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - atan_deg(TBL_IDX_W'(cnt_r));
    end
    z_rnd = (z_nxt + RND) >>> SH;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= '0;
        if (x_in == '0 && y_in == '0) begin
          done_r <= 1'b1;
        end else begin
          run_r <= 1'b1;
        end
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r     <= x_ld;
      y_r     <= y_ld;
      z_r     <= z_ld;
      angle_r <= '0;
    end else if (run_r) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      z_r     <= z_nxt;
      angle_r <= z_rnd;
    end
  end

  assign done  = done_r;
  assign angle = angle_r;

endmodule

>>> rtl/imuaf_div.sv
// constant divider by reciprocal multiplication and one correction step, shared multiplier
module imuaf_div import imuaf_pkg::*; #(
  parameter int NUM_W = 46
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic             sel_fuse,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int SHR = NUM_W - 30;
  localparam logic [31:0] GYRO_RECIP = 32'((64'd1 << (32 + SHR)) / 64'(GYRO_DIV));
  localparam logic [31:0] FUSE_RECIP = 32'((64'd1 << 36) / 64'(FUSE_DIV));

  logic [NUM_W-1:0] n_r, q_r, rem_r, rem_nxt;
  logic             fuse_r;
  logic [1:0]       ph_r;
  logic             run_r, done_r;
  logic [31:0]      mul_a, mul_b, q0_r;
  logic [63:0]      mul_p;
  logic [DEN_W-1:0] den;

  // first pass estimates the quotient from below, second pass forms the remainder
  always_comb begin
    den = fuse_r ? FUSE_DIV : GYRO_DIV;
    if (ph_r == 2'd0) begin
      mul_a = fuse_r ? n_r[31:0] : 32'(n_r >> SHR);
      mul_b = fuse_r ? FUSE_RECIP : GYRO_RECIP;
    end else begin
      mul_a = q0_r;
      mul_b = 32'(den);
    end
    mul_p   = mul_a * mul_b;
    rem_nxt = n_r - NUM_W'(mul_p);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        ph_r  <= '0;
      end else if (run_r) begin
        ph_r <= ph_r + 2'd1;
        if (ph_r == 2'd2) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= num;
      fuse_r <= sel_fuse;
    end else if (run_r) begin
      unique case (ph_r)
        2'd0: q0_r <= fuse_r ? 32'(mul_p >> 36) : mul_p[63:32];
        2'd1: rem_r <= rem_nxt;
        default: q_r <= (rem_r >= NUM_W'(den)) ? NUM_W'(q0_r) + 1'b1 : NUM_W'(q0_r);
      endcase
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

>>> rtl/imu_attitude_filter_with_safety.sv
// attitude filter top level: sequencer, filter state and safety checks
// sequence per sample: cordic passes for pitch and roll (skipping iterations when both
//   operands are zero), four divisions, safety check; a held result stalls the check
// a new sample is accepted only in idle, once the previous one has passed every step
// reset: synchronous active-low rst_n clears filter state, heartbeat tracking, stop latch
//   and loads the default limits; offsets reset to zero
module imu_attitude_filter_with_safety import imuaf_pkg::*; #(
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, elapsed_us, heartbeat, key_code
  input  logic [159:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // roll, pitch, stopped, timeout_trip, cause
  output logic [47:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [19:0]  cfg_wdata
);

  localparam int DIV_W = 38 + ANGLE_FRAC_BITS;

  state_t state_r, state_nxt;
  logic   launched_r, launched_nxt;

  logic signed [15:0] gx_off_r, gy_off_r, gz_off_r;
  logic signed [16:0] roll_off_r, pitch_off_r;
  logic [15:0]        angle_lim_r, rate_lim_r;
  logic [19:0]        beat_tmo_r;

  logic signed [15:0] ax_r, ay_r, az_r;
  logic signed [17:0] gx_r, gy_r, gz_r;
  logic [19:0]        us_r;
  logic [31:0]        beat_r;
  logic [7:0]         key_r;

  logic signed [DIV_W-1:0] pitch_a_r, pitch_a_nxt, roll_a_r, roll_a_nxt;
  logic signed [DIV_W-1:0] dlt_roll_r, dlt_roll_nxt, dlt_pitch_r, dlt_pitch_nxt;
  logic signed [OUT_ANG_W-1:0] filt_roll_r, filt_roll_nxt, filt_pitch_r, filt_pitch_nxt;
  logic [31:0]        last_beat_r, last_beat_nxt;
  logic [BEAT_W-1:0]  since_r, since_nxt;
  logic               stop_r, stop_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic signed [OUT_ANG_W-1:0] out_roll_r, out_roll_nxt, out_pitch_r, out_pitch_nxt;
  logic               out_stop_r, out_stop_nxt, out_trip_r, out_trip_nxt;
  cause_t             out_cause_r, out_cause_nxt;

  logic               in_xfer, cord_start, cord_done, div_start, div_done;
  logic signed [15:0] cord_y;
  logic signed [16:0] cord_x;
  logic signed [Z_W-1:0] cord_angle;
  logic [DIV_W-1:0]   div_num, div_quot;
  logic               div_fuse;

  logic signed [17:0]      rate_sel;
  logic [16:0]             rate_mag;
  logic [36:0]             prod;
  logic                    num_neg;
  logic signed [DIV_W-1:0] fuse_s, fuse_n, fuse_a, fuse_q, f_old;
  logic [DIV_W-1:0]        fuse_mag;
  logic signed [OUT_ANG_W-1:0] fuse_sat;
  logic signed [DIV_W-1:0] dlt_val;

  logic                    beat_chg, trip;
  logic [BEAT_W:0]         since_sum;
  logic [BEAT_W-1:0]       since_sat;
  logic signed [19:0]      fr_e, fp_e;
  logic [19:0]             fr_abs, fp_abs;
  logic [17:0]             gx_abs, gy_abs, gz_abs;
  cause_t                  cause;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gx_off_r    <= '0;
      gy_off_r    <= '0;
      gz_off_r    <= '0;
      roll_off_r  <= '0;
      pitch_off_r <= '0;
      angle_lim_r <= 16'd11520;
      rate_lim_r  <= 16'd19661;
      beat_tmo_r  <= 20'd250000;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_GYRO_X_OFF: gx_off_r    <= cfg_wdata[15:0];
        CFG_GYRO_Y_OFF: gy_off_r    <= cfg_wdata[15:0];
        CFG_GYRO_Z_OFF: gz_off_r    <= cfg_wdata[15:0];
        CFG_ROLL_OFF:   roll_off_r  <= cfg_wdata[16:0];
        CFG_PITCH_OFF:  pitch_off_r <= cfg_wdata[16:0];
        CFG_ANGLE_LIM:  angle_lim_r <= cfg_wdata[15:0];
        CFG_RATE_LIM:   rate_lim_r  <= cfg_wdata[15:0];
        CFG_BEAT_TMO:   beat_tmo_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sample capture with gyro correction
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ax_r   <= in_tdata[15:0];
      ay_r   <= in_tdata[31:16];
      az_r   <= in_tdata[47:32];
      gx_r   <= -(18'(signed'(in_tdata[63:48])) + 18'(gx_off_r));
      gy_r   <= 18'(signed'(in_tdata[79:64])) + 18'(gy_off_r);
      gz_r   <= 18'(signed'(in_tdata[95:80])) + 18'(gz_off_r);
      us_r   <= in_tdata[115:96];
      beat_r <= in_tdata[147:116];
      key_r  <= in_tdata[155:148];
    end
  end

  imuaf_cordic #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .y_in  (cord_y),
    .x_in  (cord_x),
    .done  (cord_done),
    .angle (cord_angle)
  );

  imuaf_div #(
    .NUM_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (div_num),
    .sel_fuse (div_fuse),
    .done     (div_done),
    .quot     (div_quot)
  );

  // operand selection for the shared units
  always_comb begin
    cord_x   = -(17'(az_r));
    cord_y   = (state_r == S_ROLL) ? ax_r : ay_r;
    rate_sel = (state_r == S_DELTA_P) ? gx_r : gy_r;
    rate_mag = rate_sel[17] ? 17'(-rate_sel) : 17'(rate_sel);
    prod     = rate_mag * us_r;
    if (state_r == S_FUSE_R) begin
      fuse_a = roll_a_r;
      f_old  = DIV_W'(filt_roll_r);
      fuse_s = dlt_roll_r + f_old;
    end else begin
      fuse_a = pitch_a_r;
      f_old  = DIV_W'(filt_pitch_r);
      fuse_s = dlt_pitch_r + f_old;
    end
    fuse_n   = fuse_a + (fuse_s <<< 6) - (fuse_s <<< 4) + fuse_s;
    fuse_mag = fuse_n[DIV_W-1] ? DIV_W'(-fuse_n) : DIV_W'(fuse_n);
    if (state_r == S_FUSE_R || state_r == S_FUSE_P) begin
      num_neg  = fuse_n[DIV_W-1];
      div_num  = fuse_mag + DIV_W'(FUSE_HALF);
      div_fuse = 1'b1;
    end else begin
      num_neg  = rate_sel[17];
      div_num  = (DIV_W'(prod) << ANGLE_FRAC_BITS) + DIV_W'(GYRO_HALF);
      div_fuse = 1'b0;
    end
    dlt_val = num_neg ? -signed'(div_quot) : signed'(div_quot);
    fuse_q  = dlt_val;
    if (fuse_q > DIV_W'(SAT_MAX)) begin
      fuse_sat = SAT_MAX;
    end else if (fuse_q < DIV_W'(SAT_MIN)) begin
      fuse_sat = SAT_MIN;
    end else begin
      fuse_sat = OUT_ANG_W'(fuse_q);
    end
  end

  // safety checks on the freshly filtered angles, gyro rates, heartbeat and key code
  always_comb begin
    beat_chg  = beat_r != last_beat_r;
    since_sum = (BEAT_W+1)'(since_r) + (BEAT_W+1)'(us_r);
    since_sat = since_sum[BEAT_W] ? BEAT_MAX : since_sum[BEAT_W-1:0];
    trip      = !beat_chg && (since_sat > BEAT_W'(beat_tmo_r));
    fr_e      = 20'(filt_roll_r);
    fp_e      = 20'(filt_pitch_r);
    fr_abs    = fr_e[19] ? 20'(-fr_e) : 20'(fr_e);
    fp_abs    = fp_e[19] ? 20'(-fp_e) : 20'(fp_e);
    gx_abs    = gx_r[17] ? 18'(-gx_r) : 18'(gx_r);
    gy_abs    = gy_r[17] ? 18'(-gy_r) : 18'(gy_r);
    gz_abs    = gz_r[17] ? 18'(-gz_r) : 18'(gz_r);
    priority if (key_r == SPACE_KEY) begin
      cause = CAUSE_KEY;
    end else if (fp_abs > 20'(angle_lim_r) || fr_abs > 20'(angle_lim_r)) begin
      cause = CAUSE_ANGLE;
    end else if (gx_abs > 18'(rate_lim_r) || gy_abs > 18'(rate_lim_r) ||
                 gz_abs > 18'(rate_lim_r)) begin
      cause = CAUSE_RATE;
    end else begin
      cause = CAUSE_NONE;
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    launched_nxt   = launched_r;
    cord_start     = 1'b0;
    div_start      = 1'b0;
    pitch_a_nxt    = pitch_a_r;
    roll_a_nxt     = roll_a_r;
    dlt_roll_nxt   = dlt_roll_r;
    dlt_pitch_nxt  = dlt_pitch_r;
    filt_roll_nxt  = filt_roll_r;
    filt_pitch_nxt = filt_pitch_r;
    last_beat_nxt  = last_beat_r;
    since_nxt      = since_r;
    stop_nxt       = stop_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_roll_nxt   = out_roll_r;
    out_pitch_nxt  = out_pitch_r;
    out_stop_nxt   = out_stop_r;
    out_trip_nxt   = out_trip_r;
    out_cause_nxt  = out_cause_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_PITCH;
        end
      end
      S_PITCH, S_ROLL: begin
        cord_start   = !launched_r;
        launched_nxt = 1'b1;
        if (cord_done) begin
          launched_nxt = 1'b0;
          if (state_r == S_PITCH) begin
            pitch_a_nxt = DIV_W'(cord_angle) + DIV_W'(pitch_off_r);
            state_nxt   = S_ROLL;
          end else begin
            roll_a_nxt = DIV_W'(cord_angle) + DIV_W'(roll_off_r);
            state_nxt  = S_DELTA_R;
          end
        end
      end
      S_DELTA_R, S_DELTA_P, S_FUSE_R, S_FUSE_P: begin
        div_start    = !launched_r;
        launched_nxt = 1'b1;
        if (div_done) begin
          launched_nxt = 1'b0;
          unique case (state_r)
            S_DELTA_R: begin
              dlt_roll_nxt = dlt_val;
              state_nxt    = S_DELTA_P;
            end
            S_DELTA_P: begin
              dlt_pitch_nxt = dlt_val;
              state_nxt     = S_FUSE_R;
            end
            S_FUSE_R: begin
              filt_roll_nxt = fuse_sat;
              state_nxt     = S_FUSE_P;
            end
            default: begin
              filt_pitch_nxt = fuse_sat;
              state_nxt      = S_CHECK;
            end
          endcase
        end
      end
      S_CHECK: begin
        if (!out_valid_r || out_tready) begin
          if (beat_chg) begin
            last_beat_nxt = beat_r;
            since_nxt     = '0;
          end else begin
            since_nxt = since_sat;
          end
          stop_nxt      = stop_r || trip || (cause != CAUSE_NONE);
          out_valid_nxt = 1'b1;
          out_roll_nxt  = filt_roll_r;
          out_pitch_nxt = filt_pitch_r;
          out_stop_nxt  = stop_r || trip || (cause != CAUSE_NONE);
          out_trip_nxt  = trip;
          out_cause_nxt = cause;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      launched_r   <= 1'b0;
      filt_roll_r  <= '0;
      filt_pitch_r <= '0;
      last_beat_r  <= '0;
      since_r      <= '0;
      stop_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      launched_r   <= launched_nxt;
      filt_roll_r  <= filt_roll_nxt;
      filt_pitch_r <= filt_pitch_nxt;
      last_beat_r  <= last_beat_nxt;
      since_r      <= since_nxt;
      stop_r       <= stop_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pitch_a_r   <= pitch_a_nxt;
    roll_a_r    <= roll_a_nxt;
    dlt_roll_r  <= dlt_roll_nxt;
    dlt_pitch_r <= dlt_pitch_nxt;
    out_roll_r  <= out_roll_nxt;
    out_pitch_r <= out_pitch_nxt;
    out_stop_r  <= out_stop_nxt;
    out_trip_r  <= out_trip_nxt;
    out_cause_r <= out_cause_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_cause_r, out_trip_r, out_stop_r, out_pitch_r, out_roll_r};

endmodule

>>> rtl/imuaf_checker.sv
// port-level assertions for the attitude filter, bound to the top level
module imuaf_checker import imuaf_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [159:0] in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [47:0]  out_tdata,
  input logic         cfg_we,
  input logic [2:0]   cfg_addr,
  input logic [19:0]  cfg_wdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // busy after a sample transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after input transfer");

  // any cause sets the stop flag
  a_cause_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[41:40] != CAUSE_NONE) |-> out_tdata[38])
    else $error("cause without stop");

  // a heartbeat timeout sets the stop flag
  a_trip_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[39] |-> out_tdata[38])
    else $error("timeout without stop");

endmodule

bind imu_attitude_filter_with_safety imuaf_checker u_imuaf_checker (.*);
